>>> rtl/core/ventilation_event_detector_defines.svh
// Assertion macros for the ventilation event detector.
`ifndef VENTILATION_EVENT_DETECTOR_DEFINES_SVH
`define VENTILATION_EVENT_DETECTOR_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define VED_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
// Next-cycle implication.
`define VED_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`endif

>>> rtl/core/ved_pkg.sv
// Package: types and constants for the detector.
`timescale 1ns / 1ps
`default_nettype none
package ved_pkg;
	localparam int SLOPE_DEPTH_DEF = 6;
	localparam int LOCKOUT_MS_DEF = 60000;
	localparam int REBOUND_HOLD_MS_DEF = 120000;
	localparam logic [31:0] REFRESH_MS = 32'd5400000;
	localparam logic [31:0] LOG_MS = 32'd180000;
	localparam logic [31:0] TIMEOUT_MS = 32'd3600000;
	localparam logic [31:0] CONFIRM_WIN_MS = 32'd6500;

	typedef enum logic [1:0] {
		ST_STABLE = 2'd0,
		ST_VENT = 2'd1,
		ST_TARGET = 2'd2,
		ST_INEFF = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		RSN_NONE = 4'd0,
		RSN_TRIGGER = 4'd1,
		RSN_TARGET = 4'd2,
		RSN_SLOPE = 4'd3,
		RSN_PLATEAU = 4'd4,
		RSN_TEMP = 4'd5,
		RSN_TROUGH = 4'd6,
		RSN_JUMP = 4'd7,
		RSN_BASELINE = 4'd8,
		RSN_TIMEOUT = 4'd9
	} reason_t;

	localparam logic [2:0] REG_HUM_DROP = 3'd0;
	localparam logic [2:0] REG_TEMP_DROP = 3'd1;
	localparam logic [2:0] REG_ABS_DROP = 3'd2;
	localparam logic [2:0] REG_TRIG_CONF = 3'd3;
	localparam logic [2:0] REG_PLAT_SLOPE = 3'd4;
	localparam logic [2:0] REG_PLAT_CONF = 3'd5;
	localparam logic [2:0] REG_REB_TEMP = 3'd6;
	localparam logic [2:0] REG_REB_ABS = 3'd7;

	typedef struct packed {
		logic [13:0] hum_drop;
		logic [12:0] temp_drop;
		logic [13:0] abs_drop;
		logic [3:0] trig_conf;
		logic signed [10:0] plat_slope;
		logic [3:0] plat_conf;
		logic [12:0] reb_temp;
		logic [13:0] reb_abs;
	} cfg_t;

	typedef struct packed {
		logic signed [14:0] temperature;
		logic [13:0] rel_humidity;
		logic [16:0] abs_humidity;
		logic [31:0] now_ms;
		logic clock_valid;
	} sample_t;

	typedef struct packed {
		mode_t climate_state;
		logic state_changed;
		logic [31:0] entered_at_ms;
		logic log_history;
		reason_t reason_code;
	} result_t;
endpackage
`default_nettype wire

>>> rtl/core/ved_cfg.sv
// Configuration register file.
`timescale 1ns / 1ps
`default_nettype none
module ved_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	input wire logic [2:0] cfg_index,
	input wire logic [13:0] cfg_data,
	output ved_pkg::cfg_t cfg
);
	import ved_pkg::*;
	cfg_t cfg_q;
	assign cfg = cfg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hum_drop <= 14'd300;
			cfg_q.temp_drop <= 13'd100;
			cfg_q.abs_drop <= 14'd300;
			cfg_q.trig_conf <= 4'd2;
			cfg_q.plat_slope <= -11'sd20;
			cfg_q.plat_conf <= 4'd2;
			cfg_q.reb_temp <= 13'd50;
			cfg_q.reb_abs <= 14'd500;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HUM_DROP: cfg_q.hum_drop <= cfg_data;
				REG_TEMP_DROP: cfg_q.temp_drop <= cfg_data[12:0];
				REG_ABS_DROP: cfg_q.abs_drop <= cfg_data;
				REG_TRIG_CONF: cfg_q.trig_conf <= cfg_data[3:0];
				REG_PLAT_SLOPE: cfg_q.plat_slope <= cfg_data[10:0];
				REG_PLAT_CONF: cfg_q.plat_conf <= cfg_data[3:0];
				REG_REB_TEMP: cfg_q.reb_temp <= cfg_data[12:0];
				REG_REB_ABS: cfg_q.reb_abs <= cfg_data;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/ved_core.sv
// Per-sample classifier: state registers and next-state logic.
`timescale 1ns / 1ps
`default_nettype none
module ved_core #(
	parameter int SLOPE_DEPTH = ved_pkg::SLOPE_DEPTH_DEF,
	parameter int LOCKOUT_MS = ved_pkg::LOCKOUT_MS_DEF,
	parameter int REBOUND_HOLD_MS = ved_pkg::REBOUND_HOLD_MS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input ved_pkg::sample_t smp,
	input ved_pkg::cfg_t cfg,
	output ved_pkg::result_t res
);
	import ved_pkg::*;
	localparam int IW = $clog2(SLOPE_DEPTH);
	localparam int FW = $clog2(SLOPE_DEPTH + 1);
	localparam logic [31:0] LOCK = 32'(LOCKOUT_MS);
	localparam logic [31:0] HOLD = 32'(REBOUND_HOLD_MS);

	mode_t mode_q;
	logic [31:0] entry_time_q, trough_time_q, refresh_time_q, log_time_q;
	logic signed [14:0] bt_q, tr_t_q;
	logic [13:0] bh_q, eh_q;
	logic [16:0] ba_q, prev_q, tr_a_q;
	logic seen_q, tr_t_ok_q, tr_a_ok_q, entry_ok_q, refresh_ok_q, log_ok_q;
	logic [3:0] trig_q, plat_q;
	logic [16:0] ring_q [SLOPE_DEPTH];
	logic [IW-1:0] head_q;
	logic [FW-1:0] fill_q;

	logic signed [14:0] t, cbt;
	logic [13:0] h, cbh;
	logic [16:0] a, cba, cprev;
	logic [31:0] now, since;
	mode_t nmode;
	reason_t reason;
	logic upd, bload, trig, ent_load, logd;
	logic [3:0] trig_n, plat_n, target;
	logic signed [15:0] tgt;
	logic [IW-1:0] oi, ni;
	logic [FW:0] ring_sum;
	logic signed [17:0] slope;
	logic signed [24:0] lim, slope100;
	logic [13:0] hf;
	logic signed [14:0] ntr_t;
	logic [16:0] ntr_a;
	logic [31:0] ntr_time;
	logic ntr_t_ok, ntr_a_ok, nentry_now;

	always_comb begin
		t = smp.temperature;
		h = smp.rel_humidity;
		a = smp.abs_humidity;
		now = smp.now_ms;
		cbt = seen_q ? bt_q : t;
		cbh = seen_q ? bh_q : h;
		cba = seen_q ? ba_q : a;
		cprev = seen_q ? prev_q : a;
		since = now - entry_time_q;
		nmode = mode_q;
		reason = RSN_NONE;
		upd = 1'b0;
		bload = 1'b0;
		nentry_now = 1'b0;
		ent_load = 1'b0;
		trig_n = trig_q;
		plat_n = plat_q;
		ntr_t = tr_t_q;
		ntr_a = tr_a_q;
		ntr_time = trough_time_q;
		ntr_t_ok = tr_t_ok_q;
		ntr_a_ok = tr_a_ok_q;
		trig = ($signed({2'b0, cbh}) - $signed({2'b0, h}) > $signed({2'b0, cfg.hum_drop}))
			|| ($signed({cbt[14], cbt}) - $signed({t[14], t})
				> $signed({3'b0, cfg.temp_drop}))
			|| ($signed({1'b0, cprev}) - $signed({1'b0, a})
				> $signed({4'b0, cfg.abs_drop}));
		target = (since < CONFIRM_WIN_MS) ? cfg.trig_conf : 4'd1;
		tgt = '0; oi = '0; ni = '0; ring_sum = '0; slope = '0; lim = '0; slope100 = '0;
		hf = '0;
		if (mode_q == ST_STABLE) begin
			plat_n = '0;
			ntr_t_ok = 1'b0;
			ntr_a_ok = 1'b0;
			if (trig && since >= LOCK) begin
				trig_n = (trig_q == 4'd15) ? 4'd15 : trig_q + 4'd1;
				if (trig_n >= target) begin
					nmode = ST_VENT; nentry_now = 1'b1; ent_load = 1'b1;
					upd = 1'b1; bload = 1'b1; trig_n = '0; reason = RSN_TRIGGER;
				end
			end else begin
				trig_n = '0;
			end
			if (!refresh_ok_q || now - refresh_time_q >= REFRESH_MS) begin
				upd = 1'b1; bload = 1'b1;
			end
		end else begin
			if (mode_q == ST_VENT) begin
				tgt = entry_ok_q ? $signed({2'b0, eh_q}) - 16'sd1500 : 16'sd0;
				if (tgt < 16'sd5000) tgt = 16'sd5000;
				// oldest and newest ring entries, wrapped without a divider
				ring_sum = (FW+1)'(head_q) + (FW+1)'(SLOPE_DEPTH) - (FW+1)'(fill_q);
				oi = IW'((ring_sum >= (FW+1)'(SLOPE_DEPTH)) ?
					ring_sum - (FW+1)'(SLOPE_DEPTH) : ring_sum);
				ni = (head_q == '0) ? IW'(SLOPE_DEPTH - 1) : head_q - 1'b1;
				slope = $signed({1'b0, ring_q[ni]}) - $signed({1'b0, ring_q[oi]});
				hf = (eh_q < 14'd5000) ? 14'd5000 : (eh_q > 14'd7000) ? 14'd7000 : eh_q;
				lim = 25'(cfg.plat_slope) * 25'sd100;
				if (entry_ok_q) lim = lim - 25'sd3 * $signed({11'b0, hf - 14'd5000});
				slope100 = 25'(slope) * 25'sd100;
				if ($signed({2'b0, h}) <= tgt) begin
					nmode = ST_TARGET; nentry_now = 1'b1; upd = 1'b1; bload = 1'b1;
					reason = RSN_TARGET;
				end else if (since > LOG_MS && fill_q >= FW'(3)) begin
					if (slope > 18'sd50) begin
						nmode = ST_STABLE; nentry_now = 1'b1; upd = 1'b1; bload = 1'b1;
						reason = RSN_SLOPE;
					end else if (slope100 > lim) begin
						plat_n = (plat_q == 4'd15) ? 4'd15 : plat_q + 4'd1;
						if (plat_n >= cfg.plat_conf) begin
							nmode = ST_INEFF; nentry_now = 1'b1; upd = 1'b1; bload = 1'b1;
							reason = RSN_PLATEAU;
						end
					end else begin
						plat_n = '0;
					end
				end
			end
			if (nmode != ST_STABLE) begin
				if (!tr_t_ok_q || t < tr_t_q) begin
					ntr_t = t; ntr_time = now; ntr_t_ok = 1'b1;
				end
				if (!tr_a_ok_q || a < tr_a_q) begin
					ntr_a = a; ntr_a_ok = 1'b1;
				end
				if ($signed({t[14], t}) - $signed({ntr_t[14], ntr_t})
						>= $signed({3'b0, cfg.reb_temp}) && now - ntr_time >= HOLD) begin
					nmode = ST_STABLE; reason = RSN_TEMP;
				end
				if (nmode != ST_STABLE && {1'b0, a} > {1'b0, ntr_a} + 18'd150) begin
					nmode = ST_STABLE; reason = RSN_TROUGH;
				end
				if (nmode != ST_STABLE && {1'b0, a} > {1'b0, cprev} + 18'd300) begin
					nmode = ST_STABLE; reason = RSN_JUMP;
				end
				if (nmode != ST_STABLE && $signed({1'b0, a}) - $signed({1'b0, cba})
						> $signed({4'b0, cfg.reb_abs})) begin
					nmode = ST_STABLE; reason = RSN_BASELINE;
				end
				if (nmode != ST_STABLE && since > TIMEOUT_MS) begin
					nmode = ST_STABLE; reason = RSN_TIMEOUT;
				end
				// rebound exits restart the refresh timer but keep the baseline
				if (reason >= RSN_TEMP) begin
					nentry_now = 1'b1; upd = 1'b1;
				end
			end
		end
		logd = smp.clock_valid && (!log_ok_q || now - log_time_q >= LOG_MS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ST_STABLE;
			entry_time_q <= '0;
			seen_q <= 1'b0;
			bt_q <= '0; bh_q <= '0; ba_q <= '0; prev_q <= '0;
			trig_q <= '0; plat_q <= '0;
			tr_t_ok_q <= 1'b0; tr_a_ok_q <= 1'b0; entry_ok_q <= 1'b0;
			refresh_ok_q <= 1'b0; log_ok_q <= 1'b0;
			trough_time_q <= '0; refresh_time_q <= '0; log_time_q <= '0;
			head_q <= '0; fill_q <= '0;
			res <= '0;
		end else if (step) begin
			seen_q <= 1'b1;
			mode_q <= nmode;
			if (nentry_now) entry_time_q <= now;
			trig_q <= trig_n;
			plat_q <= plat_n;
			tr_t_ok_q <= ntr_t_ok;
			tr_a_ok_q <= ntr_a_ok;
			trough_time_q <= ntr_time;
			if (ent_load) entry_ok_q <= 1'b1;
			prev_q <= a;
			if (bload || !seen_q) begin
				bt_q <= t; bh_q <= h; ba_q <= a;
			end
			if (upd) begin
				refresh_time_q <= now; refresh_ok_q <= 1'b1;
			end
			if (logd) begin
				log_time_q <= now; log_ok_q <= 1'b1;
			end
			if (nmode == ST_STABLE) begin
				head_q <= '0; fill_q <= '0;
			end else if (logd) begin
				head_q <= (head_q == IW'(SLOPE_DEPTH - 1)) ? '0 : head_q + 1'b1;
				if (fill_q < FW'(SLOPE_DEPTH)) fill_q <= fill_q + 1'b1;
			end
			res.climate_state <= nmode;
			res.state_changed <= (nmode != mode_q);
			res.entered_at_ms <= nentry_now ? now : entry_time_q;
			res.log_history <= logd;
			res.reason_code <= (nmode != mode_q) ? reason : RSN_NONE;
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (step) begin
			tr_t_q <= ntr_t;
			tr_a_q <= ntr_a;
			if (ent_load) begin
				eh_q <= h;
			end
			if (logd && nmode != ST_STABLE) ring_q[head_q] <= a;
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/ventilation_event_detector.sv
// Ventilation event detector, top level.
// One climate sample per request, one result per sample. The classifier is a
// single register stage: a sample is taken in any cycle the result register is
// free or being drained, and its result is valid in the next cycle, so the
// sustained rate is one sample per clock while m_tready stays high. Configuration
// writes go to a small register file and must happen while no result is pending.
`timescale 1ns / 1ps
`default_nettype none
`include "ventilation_event_detector_defines.svh"
module ventilation_event_detector #(
	parameter int SLOPE_DEPTH = ved_pkg::SLOPE_DEPTH_DEF,
	parameter int LOCKOUT_MS = ved_pkg::LOCKOUT_MS_DEF,
	parameter int REBOUND_HOLD_MS = ved_pkg::REBOUND_HOLD_MS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// temperature[14:0], rel_humidity[28:15], abs_humidity[45:29], now_ms[77:46]
	input wire logic [79:0] s_tdata,
	// clock_valid
	input wire logic s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// climate_state[1:0], state_changed[2], entered_at_ms[34:3],
	// log_history[35], reason_code[39:36]
	output logic [39:0] m_tdata,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [13:0] cfg_data
);
	import ved_pkg::*;
	cfg_t cfg;
	sample_t smp;
	result_t res;
	logic step, valid_q;

	assign cfg_ready = 1'b1;
	assign s_tready = !valid_q || m_tready;
	assign step = s_tvalid && s_tready;
	assign m_tvalid = valid_q;
	assign smp.temperature = s_tdata[14:0];
	assign smp.rel_humidity = s_tdata[28:15];
	assign smp.abs_humidity = s_tdata[45:29];
	assign smp.now_ms = s_tdata[77:46];
	assign smp.clock_valid = s_tuser;
	assign m_tdata = {res.reason_code, res.log_history, res.entered_at_ms,
		res.state_changed, res.climate_state};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	ved_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
	);

	ved_core #(
		.SLOPE_DEPTH(SLOPE_DEPTH), .LOCKOUT_MS(LOCKOUT_MS),
		.REBOUND_HOLD_MS(REBOUND_HOLD_MS)
	) u_core (
		.clk(clk), .arst_n(arst_n), .step(step), .smp(smp), .cfg(cfg), .res(res)
	);

	`VED_ASSERT_NEXT(a_step_valid, step, m_tvalid, "accepted sample gave no result")
	`VED_ASSERT(a_reason_change, m_tvalid && !m_tdata[2], m_tdata[39:36] == RSN_NONE, "reason without state change")
	`VED_ASSERT(a_change_reason, m_tvalid && m_tdata[2], m_tdata[39:36] != RSN_NONE, "state change without reason")
endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the ventilation event detector.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import ved_pkg::*;

	// lowest field last, matching the result bus packing
	typedef struct packed {
		logic [3:0] reason_code;
		logic log_history;
		logic [31:0] entered_at_ms;
		logic state_changed;
		logic [1:0] climate_state;
	} outcome_t;

	typedef struct {
		logic signed [14:0] temp;
		logic [13:0] hum;
		logic [16:0] abshum;
		logic [31:0] now;
		logic clk_ok;
	} sample_s;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [79:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [13:0] cfg_data = '0;

	ventilation_event_detector dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// detector model state
	logic [13:0] r_hum_drop, r_abs_drop, r_reb_abs;
	logic [12:0] r_temp_drop, r_reb_temp;
	logic [3:0] r_trig_conf, r_plat_conf;
	logic signed [10:0] r_plat_slope;
	logic [1:0] m_mode;
	logic [31:0] m_entry, m_trough_time, m_refresh_time, m_log_time;
	int m_bt, m_bh, m_ba, m_prev_a, m_trough_t, m_trough_a, m_entry_h;
	bit m_seen, m_trough_t_ok, m_trough_a_ok, m_entry_ok, m_refresh_done, m_log_done;
	int unsigned m_trig_tally, m_plat_tally, m_head, m_fill;
	int m_ring[6];

	sample_s pending_samples[$];
	outcome_t expected_outcomes[$];
	int mismatches = 0;
	int n_results = 0;
	int n_changes = 0;
	bit [15:0] reasons_seen = '0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	bit hold_off = 1'b0;
	bit timed_out = 1'b0;

	task automatic detector_reset();
		r_hum_drop = 300; r_temp_drop = 100; r_abs_drop = 300; r_trig_conf = 2;
		r_plat_slope = -11'sd20; r_plat_conf = 2; r_reb_temp = 50; r_reb_abs = 500;
		m_mode = ST_STABLE; m_entry = 0; m_bt = 0; m_bh = 0; m_ba = 0; m_seen = 0;
		m_prev_a = 0; m_trig_tally = 0; m_plat_tally = 0; m_trough_t = 0; m_trough_a = 0;
		m_entry_h = 0; m_trough_t_ok = 0; m_trough_a_ok = 0; m_entry_ok = 0;
		m_trough_time = 0; m_refresh_time = 0; m_log_time = 0; m_refresh_done = 0;
		m_log_done = 0; m_head = 0; m_fill = 0;
		foreach (m_ring[i]) m_ring[i] = 0;
	endtask

	function automatic outcome_t classify_sample(sample_s s);
		int t, h, a, tgt, slope, lim, hf;
		logic [31:0] now, since, nentry;
		logic [1:0] old_mode, nmode;
		logic [3:0] reason;
		bit upd, logged, trig;
		int unsigned target, oi, ni;
		int nbt, nbh, nba;
		outcome_t o;
		t = s.temp; h = s.hum; a = s.abshum; now = s.now;
		old_mode = m_mode; nmode = m_mode; nentry = m_entry;
		reason = RSN_NONE; upd = 0; logged = 0;
		if (!m_seen) begin
			m_seen = 1; m_bt = t; m_bh = h; m_ba = a; m_prev_a = a;
		end
		nbt = m_bt; nbh = m_bh; nba = m_ba;
		since = now - m_entry;
		if (m_mode == ST_STABLE) begin
			trig = (m_bh - h) > int'(r_hum_drop) || (m_bt - t) > int'(r_temp_drop)
				|| (m_prev_a - a) > int'(r_abs_drop);
			target = (since < CONFIRM_WIN_MS) ? r_trig_conf : 1;
			m_plat_tally = 0; m_trough_t_ok = 0; m_trough_a_ok = 0;
			if (trig && since >= LOCKOUT_MS_DEF) begin
				if (m_trig_tally < 15) m_trig_tally++;
				if (m_trig_tally >= target) begin
					nmode = ST_VENT; nentry = now; m_entry_h = h; m_entry_ok = 1;
					upd = 1; nbt = t; nbh = h; nba = a; m_trig_tally = 0;
					reason = RSN_TRIGGER;
				end
			end else
				m_trig_tally = 0;
			if (!m_refresh_done || now - m_refresh_time >= REFRESH_MS) begin
				upd = 1; nbt = t; nbh = h; nba = a;
			end
		end else begin
			if (m_mode == ST_VENT) begin
				tgt = m_entry_ok ? m_entry_h - 1500 : 0;
				if (tgt < 5000) tgt = 5000;
				if (h <= tgt) begin
					nmode = ST_TARGET; nentry = now; upd = 1;
					nbt = t; nbh = h; nba = a; reason = RSN_TARGET;
				end else if (since > LOG_MS && m_fill >= 3) begin
					oi = (m_head + 6 - m_fill) % 6;
					ni = (m_head + 5) % 6;
					slope = m_ring[ni] - m_ring[oi];
					lim = 100 * int'(r_plat_slope);
					if (m_entry_ok) begin
						hf = m_entry_h;
						if (hf < 5000) hf = 5000;
						if (hf > 7000) hf = 7000;
						lim -= 3 * (hf - 5000);
					end
					if (slope > 50) begin
						nmode = ST_STABLE; nentry = now; upd = 1;
						nbt = t; nbh = h; nba = a; reason = RSN_SLOPE;
					end else if (100 * slope > lim) begin
						if (m_plat_tally < 15) m_plat_tally++;
						if (m_plat_tally >= r_plat_conf) begin
							nmode = ST_INEFF; nentry = now; upd = 1;
							nbt = t; nbh = h; nba = a; reason = RSN_PLATEAU;
						end
					end else
						m_plat_tally = 0;
				end
			end
			if (nmode != ST_STABLE) begin
				if (!m_trough_t_ok || t < m_trough_t) begin
					m_trough_t = t; m_trough_time = now; m_trough_t_ok = 1;
				end
				if (!m_trough_a_ok || a < m_trough_a) begin
					m_trough_a = a; m_trough_a_ok = 1;
				end
				if (t - m_trough_t >= int'(r_reb_temp)
						&& now - m_trough_time >= REBOUND_HOLD_MS_DEF) begin
					nmode = ST_STABLE; reason = RSN_TEMP;
				end
				if (nmode != ST_STABLE && a > m_trough_a + 150) begin
					nmode = ST_STABLE; reason = RSN_TROUGH;
				end
				if (nmode != ST_STABLE && a > m_prev_a + 300) begin
					nmode = ST_STABLE; reason = RSN_JUMP;
				end
				if (nmode != ST_STABLE && (a - m_ba) > int'(r_reb_abs)) begin
					nmode = ST_STABLE; reason = RSN_BASELINE;
				end
				if (nmode != ST_STABLE && since > TIMEOUT_MS) begin
					nmode = ST_STABLE; reason = RSN_TIMEOUT;
				end
				if (reason >= RSN_TEMP) begin
					nentry = now; upd = 1;
				end
			end
		end
		m_mode = nmode; m_entry = nentry;
		if (upd) begin
			m_bt = nbt; m_bh = nbh; m_ba = nba; m_refresh_time = now; m_refresh_done = 1;
		end
		if (m_mode == ST_STABLE) begin
			m_head = 0; m_fill = 0;
		end
		m_prev_a = a;
		if (s.clk_ok && (!m_log_done || now - m_log_time >= LOG_MS)) begin
			logged = 1; m_log_time = now; m_log_done = 1;
			if (m_mode != ST_STABLE) begin
				m_ring[m_head] = a;
				m_head = (m_head + 1) % 6;
				if (m_fill < 6) m_fill++;
			end
		end
		o.climate_state = m_mode;
		o.state_changed = (m_mode != old_mode);
		o.entered_at_ms = m_entry;
		o.log_history = logged;
		o.reason_code = (m_mode != old_mode) ? reason : RSN_NONE;
		return o;
	endfunction

	// request driver
	always @(posedge clk) begin
		sample_s s;
		if (s_tvalid && s_tready) begin
			expected_outcomes.push_back(classify_sample(pending_samples.pop_front()));
		end
		if ((!s_tvalid || s_tready)) begin
			if (pending_samples.size() > 0 && (s_tvalid && s_tready ?
					pending_samples.size() > 0 : 1'b1)
					&& $urandom_range(99) >= send_idle_pct) begin
				s = pending_samples[0];
				s_tvalid <= 1'b1;
				s_tdata <= {2'b0, s.now, s.abshum, s.hum, s.temp};
				s_tuser <= s.clk_ok;
			end else
				s_tvalid <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		outcome_t got, exp_o;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			n_results++;
			if (got.state_changed) begin
				n_changes++;
				reasons_seen[got.reason_code] = 1'b1;
			end
			if (expected_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", m_tdata);
			end else begin
				exp_o = expected_outcomes.pop_front();
				if (got !== exp_o) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d: exp st=%0d ch=%0d at=%0d log=%0d rsn=%0d, got st=%0d ch=%0d at=%0d log=%0d rsn=%0d",
							n_results, exp_o.climate_state, exp_o.state_changed,
							exp_o.entered_at_ms, exp_o.log_history, exp_o.reason_code,
							got.climate_state, got.state_changed, got.entered_at_ms,
							got.log_history, got.reason_code);
				end
			end
		end
		m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// cycle guard
	int cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// sample generator state
	logic [31:0] g_now;
	int g_t, g_h, g_a;

	task automatic push_sample(int t, int h, int a, logic [31:0] now, bit ck);
		sample_s s;
		s.temp = 15'(t); s.hum = 14'(h); s.abshum = 17'(a); s.now = now; s.clk_ok = ck;
		pending_samples.push_back(s);
	endtask

	function automatic int clampi(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	task automatic wait_drained();
		while (pending_samples.size() > 0 || s_tvalid || expected_outcomes.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [13:0] val);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_HUM_DROP: r_hum_drop = val;
			REG_TEMP_DROP: r_temp_drop = val[12:0];
			REG_ABS_DROP: r_abs_drop = val;
			REG_TRIG_CONF: r_trig_conf = val[3:0];
			REG_PLAT_SLOPE: r_plat_slope = val[10:0];
			REG_PLAT_CONF: r_plat_conf = val[3:0];
			REG_REB_TEMP: r_reb_temp = val[12:0];
			default: r_reb_abs = val;
		endcase
		// idling with cfg_valid low keeps the next write off this time step
		@(posedge clk);
	endtask

	// one ventilation episode: quiet, a drop, then drying with random flavor
	task automatic push_episode();
		int n, kind;
		n = $urandom_range(3, 8);
		repeat (n) begin
			g_now += $urandom_range(20000, 90000);
			g_t = clampi(g_t + $urandom_range(0, 20) - 10, -4000, 8500);
			g_h = clampi(g_h + $urandom_range(0, 20) - 10, 0, 10000);
			push_sample(g_t, g_h, g_a, g_now, $urandom_range(9) != 0);
		end
		g_t = clampi(g_t - $urandom_range(50, 400), -4000, 8500);
		g_h = clampi(g_h - $urandom_range(100, 800), 0, 10000);
		g_a = clampi(g_a - $urandom_range(100, 900), 0, 100000);
		kind = $urandom_range(3);
		n = $urandom_range(8, 30);
		repeat (n) begin
			g_now += (kind == 3) ? $urandom_range(100000, 400000) : $urandom_range(20000, 120000);
			case (kind)
				0: begin g_h = clampi(g_h - $urandom_range(0, 300), 0, 10000);
					g_a = clampi(g_a - $urandom_range(0, 200), 0, 100000); end
				1: begin g_h = clampi(g_h - $urandom_range(0, 20), 0, 10000);
					g_a = clampi(g_a + $urandom_range(0, 20) - 10, 0, 100000); end
				2: begin g_t = clampi(g_t + $urandom_range(0, 60), -4000, 8500);
					g_a = clampi(g_a + $urandom_range(0, 250), 0, 100000); end
				default: begin g_t = clampi(g_t + $urandom_range(0, 10) - 5, -4000, 8500);
					g_h = clampi(g_h + $urandom_range(0, 10) - 5, 0, 10000); end
			endcase
			push_sample(g_t, g_h, g_a, g_now, $urandom_range(9) != 0);
		end
	endtask

	task automatic push_noise();
		g_now = $urandom_range(7) == 0 ? $urandom : g_now + $urandom_range(0, 300000);
		push_sample($urandom_range(0, 12500) - 4000, $urandom_range(0, 10000),
			$urandom_range(0, 100000), g_now, $urandom_range(1));
	endtask

	task automatic run_random(int count);
		int target;
		target = pending_samples.size() + count;
		while (pending_samples.size() < target) begin
			if ($urandom_range(9) < 8) push_episode();
			else push_noise();
		end
		wait_drained();
	endtask

	initial begin
		detector_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: field extremes, then one scripted episode
		push_sample(-4000, 0, 0, 32'd0, 1'b1);
		push_sample(8500, 10000, 100000, 32'hFFFF_FFFF, 1'b0);
		push_sample(-16384, 16383, 131071, 32'h7FFF_FFFF, 1'b1);
		push_sample(16383, 0, 0, 32'h8000_0000, 1'b1);
		g_now = 32'h8000_0000; g_t = 2000; g_h = 6000; g_a = 9000;
		push_sample(g_t, g_h, g_a, g_now + 70000, 1'b1);
		push_sample(g_t - 300, g_h - 600, g_a - 400, g_now + 75000, 1'b1);
		push_sample(g_t - 300, g_h - 600, g_a - 400, g_now + 80000, 1'b1);
		push_sample(g_t - 300, 4000, g_a - 500, g_now + 90000, 1'b1);
		g_now += 90000;
		repeat (8) begin
			g_now += 60000;
			push_sample(g_t, g_h, g_a + 400, g_now, 1'b1);
		end
		g_now += 4000000;
		push_sample(g_t, g_h, g_a, g_now, 1'b1);
		g_now = 32'hFFFF_0000;
		wait_drained();
		run_random(250);
		// extremes of the configuration
		write_reg(REG_HUM_DROP, 14'd0); write_reg(REG_TEMP_DROP, 14'd0);
		write_reg(REG_ABS_DROP, 14'd0); write_reg(REG_TRIG_CONF, 14'd1);
		write_reg(REG_PLAT_SLOPE, 14'h3FF); write_reg(REG_PLAT_CONF, 14'd1);
		write_reg(REG_REB_TEMP, 14'd0); write_reg(REG_REB_ABS, 14'd0);
		send_idle_pct = 48;
		run_random(220);
		write_reg(REG_HUM_DROP, 14'd10000); write_reg(REG_TEMP_DROP, 14'd5000);
		write_reg(REG_ABS_DROP, 14'd10000); write_reg(REG_TRIG_CONF, 14'd15);
		write_reg(REG_PLAT_SLOPE, 14'h400); write_reg(REG_PLAT_CONF, 14'd15);
		write_reg(REG_REB_TEMP, 14'd5000); write_reg(REG_REB_ABS, 14'd10000);
		send_idle_pct = 0; recv_stall_pct = 48;
		run_random(220);
		write_reg(REG_HUM_DROP, 14'd150); write_reg(REG_TEMP_DROP, 14'd40);
		write_reg(REG_ABS_DROP, 14'd200); write_reg(REG_TRIG_CONF, 14'd3);
		write_reg(REG_PLAT_SLOPE, 14'h7EC); write_reg(REG_PLAT_CONF, 14'd2);
		write_reg(REG_REB_TEMP, 14'd80); write_reg(REG_REB_ABS, 14'd700);
		send_idle_pct = 15; recv_stall_pct = 15;
		fork
			run_random(220);
			begin
				hold_off = 1'b1;
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
		join
		send_idle_pct = 0; recv_stall_pct = 0;
		run_random(200);
		repeat (20) @(posedge clk);
		$display("%0d results checked, %0d state changes, reason codes seen mask %b",
			n_results, n_changes, reasons_seen);
		if (mismatches == 0 && expected_outcomes.size() == 0)
			$display("RESULT: OK");
		else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_outcomes.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> sim.f
+incdir+rtl/core
rtl/core/ved_pkg.sv
rtl/core/ved_cfg.sv
rtl/core/ved_core.sv
rtl/core/ventilation_event_detector.sv
tb/tb.sv
